[rtl/core/assert_macros.svh]
// Assertion macros shared by the AES core modules.
// Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/aes_pkg.sv]
// Shared types, constants and S-box functions for the AES core.
// No dependencies.
package aes_pkg;
  localparam int unsigned MaxRoundKeysDef = 15;
  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    CFG_KEY0 = 3'd0, CFG_KEY1 = 3'd1, CFG_KEY2 = 3'd2, CFG_KEY3 = 3'd3,
    CFG_KEYLEN = 3'd4, CFG_MODE = 3'd5, CFG_IVH = 3'd6, CFG_IVL = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXPAND, ST_RUN, ST_DONE
  } core_state_e;

  typedef struct packed {
    logic         decrypt;
    logic         cbc;
    logic         first;
    logic [127:0] data;
  } job_t;

  // Entry 0 sits in the top byte.
  localparam logic [2047:0] SboxTbl = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SboxTbl[{~a, 3'b111} -: 8];
  endfunction

  // Inverse S-box by search over the forward table, constant logic.
  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == a) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte 0 of the block sits in bits 127:120.
  function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t, m;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*c) -: 8] = sbox(get_b(s, r + 4*((c+r)%4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1); a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
      m[127-8*(4*c) -: 8]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return last ? t : m;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] r, x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ x;
      x = xt(x);
    end
    return r;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1); a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      m[127-8*(4*c) -: 8]   = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
      m[127-8*(4*c+1) -: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
      m[127-8*(4*c+2) -: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
      m[127-8*(4*c+3) -: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
    end
    return m;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(get_b(s, r + 4*c));
      end
    end
    return t;
  endfunction
endpackage

[rtl/core/aes_front.sv]
// Front end: accepts items, tags them with mode, holds a two-entry queue.
// Depends on aes_pkg.
module aes_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic              first_block_i,
  input  logic [63:0]       block_high_i,
  input  logic [63:0]       block_low_i,
  input  logic              cbc_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output aes_pkg::job_t     job_o
);
  import aes_pkg::*;
  `include "assert_macros.svh"

  job_t       q_mem [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = job_valid_o && job_ready_i;
  assign job_o = q_mem[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= '{decrypt: command_i, cbc: cbc_i, first: first_block_i,
                       data: {block_high_i, block_low_i}};
    end
  end

  `ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q <= 2'd2)
  `ASSERT_NEXT(a_push_cnt, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
  `ASSERT_NEXT(a_pop_cnt, pop && !push, cnt_q == $past(cnt_q) - 2'd1)
endmodule

[rtl/core/aes_back.sv]
// Back end: key expansion into the round-key store and iterative rounds.
// Depends on aes_pkg.
module aes_back #(
  parameter int unsigned MaxRoundKeys = aes_pkg::MaxRoundKeysDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  aes_pkg::job_t     job_i,
  input  logic [255:0]      key_i,
  input  logic [1:0]        key_len_i,
  input  logic              key_dirty_i,
  input  logic [127:0]      iv_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       result_high_o,
  output logic [63:0]       result_low_o
);
  import aes_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned RkW = $clog2(MaxRoundKeys);
  localparam int unsigned WW  = $clog2(4 * MaxRoundKeys + 1);

  core_state_e  st_q, st_d;
  logic [127:0] rk_mem [MaxRoundKeys];
  logic [127:0] rk_rd_q;
  logic [RkW-1:0] rk_raddr;
  logic         ready_q, ready_d;
  logic [3:0]   nk_q, nk_d;
  logic [3:0]   nr_q, nr_d;
  logic [31:0]  win_q [8];
  logic [31:0]  win_d [8];
  logic [WW-1:0] wi_q, wi_d;
  logic [2:0]   kpos_q, kpos_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [95:0]  kbuf_q, kbuf_d;
  logic [1:0]   kfill_q, kfill_d;
  logic         kwr;
  logic [RkW-1:0] kwaddr;
  logic [127:0] st_val_q, st_val_d;
  logic [127:0] chain_q, chain_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         dec_q, dec_d, cbc_q, cbc_d;
  logic [127:0] cin_q, cin_d;
  logic [127:0] res_q, res_d;
  logic         ov_q, ov_d;
  logic [3:0]   nk_sel;
  logic [31:0]  tw, wnew;
  logic [127:0] cv, tmp;

  always_comb begin
    nk_sel = (key_len_i == 2'd0) ? 4'd4 : (key_len_i == 2'd1) ? 4'd6 : 4'd8;
    if (nk_sel == 4'd8 && 32'(nk_sel) + 7 > MaxRoundKeys) nk_sel = 4'd6;
    if (nk_sel == 4'd6 && 32'(nk_sel) + 7 > MaxRoundKeys) nk_sel = 4'd4;
  end

  always_comb begin
    tw = win_q[3'(nk_q - 4'd1)];
    if (kpos_q == 3'd0) begin
      tw = subst_word({tw[23:0], tw[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk_q == 4'd8 && kpos_q == 3'd4) begin
      tw = subst_word(tw);
    end
    wnew = win_q[0] ^ tw;
  end

  assign job_ready_o = (st_q == ST_IDLE) && ready_q && !key_dirty_i && !ov_q;

  always_comb begin
    rk_raddr = '0;
    case (st_q)
      ST_IDLE: rk_raddr = job_i.decrypt ? RkW'(nr_q) : '0;
      ST_DONE, ST_RUN: rk_raddr = dec_q ? RkW'(rnd_q - 4'd1) : RkW'(rnd_q + 4'd1);
      default: rk_raddr = '0;
    endcase
  end

  always_comb begin
    st_d = st_q; ready_d = ready_q; nk_d = nk_q; nr_d = nr_q;
    win_d = win_q; wi_d = wi_q; kpos_d = kpos_q; rcon_d = rcon_q;
    kbuf_d = kbuf_q; kfill_d = kfill_q; kwr = 1'b0; kwaddr = '0;
    st_val_d = st_val_q; chain_d = chain_q; rnd_d = rnd_q;
    dec_d = dec_q; cbc_d = cbc_q; cin_d = cin_q; res_d = res_q; ov_d = ov_q;
    cv = chain_q; tmp = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (key_dirty_i) ready_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!ready_q && !key_dirty_i && job_valid_i && !ov_q) begin
          nk_d = nk_sel;
          nr_d = nk_sel + 4'd6;
          for (int i = 0; i < 8; i++) win_d[i] = key_i[255-32*i -: 32];
          wi_d = '0; kpos_d = '0; rcon_d = 8'h01; kfill_d = '0;
          st_d = ST_EXPAND;
        end else if (job_valid_i && job_ready_o) begin
          if (job_i.cbc && job_i.first) cv = iv_i;
          dec_d = job_i.decrypt; cbc_d = job_i.cbc; cin_d = cv;
          chain_d = cv;
          st_val_d = (!job_i.decrypt && job_i.cbc) ? (job_i.data ^ cv) : job_i.data;
          if (job_i.decrypt && job_i.cbc) chain_d = job_i.data;
          rnd_d = job_i.decrypt ? nr_q : 4'd0;
          st_d = ST_DONE;
        end
      end
      ST_EXPAND: begin
        // Emit one word per cycle from the window head, slide in the next.
        kbuf_d = {kbuf_q[63:0], win_q[0]};
        kfill_d = kfill_q + 2'd1;
        if (kfill_q == 2'd3) begin
          kwr = 1'b1;
          kwaddr = RkW'(wi_q >> 2);
        end
        for (int i = 0; i < 7; i++) win_d[i] = win_q[i+1];
        win_d[3'(nk_q - 4'd1)] = wnew;
        kpos_d = (kpos_q == 3'(nk_q - 4'd1)) ? 3'd0 : kpos_q + 3'd1;
        if (kpos_q == 3'(nk_q - 4'd1)) rcon_d = xt(rcon_q);
        wi_d = wi_q + WW'(1);
        if (kfill_q == 2'd3 && (wi_q >> 2) == WW'(nr_q)) begin
          ready_d = !key_dirty_i;
          st_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        // First key addition, read data of round key is now valid.
        st_val_d = st_val_q ^ rk_rd_q;
        rnd_d = dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
        st_d = ST_RUN;
      end
      ST_RUN: begin
        if (!dec_q) begin
          tmp = enc_round(st_val_q, rnd_q == nr_q) ^ rk_rd_q;
        end else begin
          tmp = inv_shift_sub(st_val_q) ^ rk_rd_q;
          if (rnd_q != 4'd0) tmp = inv_mix(tmp);
        end
        st_val_d = tmp;
        if ((!dec_q && rnd_q == nr_q) || (dec_q && rnd_q == 4'd0)) begin
          res_d = (dec_q && cbc_q) ? (tmp ^ cin_q) : tmp;
          if (!dec_q && cbc_q) chain_d = tmp;
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end else begin
          rnd_d = dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ready_q <= 1'b0;
      ov_q <= 1'b0;
      chain_q <= '0;
      nk_q <= 4'd4;
      nr_q <= 4'd10;
    end else begin
      st_q <= st_d;
      ready_q <= ready_d;
      ov_q <= ov_d;
      chain_q <= chain_d;
      nk_q <= nk_d;
      nr_q <= nr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d; wi_q <= wi_d; kpos_q <= kpos_d; rcon_q <= rcon_d;
    kbuf_q <= kbuf_d; kfill_q <= kfill_d; st_val_q <= st_val_d; rnd_q <= rnd_d;
    dec_q <= dec_d; cbc_q <= cbc_d; cin_q <= cin_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (kwr) rk_mem[kwaddr] <= {kbuf_q, win_q[0]};
    rk_rd_q <= rk_mem[rk_raddr];
  end

  assign out_valid_o   = ov_q;
  assign result_high_o = res_q[127:64];
  assign result_low_o  = res_q[63:0];

  `ASSERT_IMPL(a_accept_ready, job_valid_i && job_ready_o, ready_q && !ov_q)
  `ASSERT_NEXT(a_run_to_out, st_q == ST_RUN && st_d == ST_IDLE, ov_q)
  `ASSERT_IMPL(a_nr_range, 1'b1, nr_q < 4'(MaxRoundKeys))
endmodule

[rtl/core/aes_block_cipher_ecb_cbc.sv]
// Top level of the AES ECB/CBC core: configuration registers, front, back.
// Depends on aes_pkg, aes_front, aes_back.
//
// Usage: write key, key_length, chaining_mode and IV through cfg_we_i /
// cfg_idx_i / cfg_data_i while the core is idle. Send blocks on the in_*
// valid/ready channel; results return on the out_* valid/ready channel in
// order, one per item.
// The first item after reset or a key change waits for key expansion. An item
// that enters an idle core passes the first key addition, the rounds and the
// result register in turn. The next item is not taken before the last result
// has left the result register: one shared round unit does one round per
// cycle, fed by the registered round-key memory read.
// A two-entry queue holds accepted items while the round unit is busy.
// Reset clears the chaining value to zero, marks the key store stale and
// empties the queue. A stalled receiver holds the result register; the
// round unit takes no new item until it drains, and the queue fills up.
module aes_block_cipher_ecb_cbc #(
  parameter int unsigned MaxRoundKeys = aes_pkg::MaxRoundKeysDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic                       first_block_i,
  input  logic [63:0]                block_high_i,
  input  logic [63:0]                block_low_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [63:0]                result_high_o,
  output logic [63:0]                result_low_o
);
  import aes_pkg::*;

  logic [63:0]  key_q [4];
  logic [1:0]   klen_q;
  logic         mode_q;
  logic [63:0]  ivh_q, ivl_q;
  logic         dirty;
  logic         job_valid, job_ready;
  job_t         job;

  assign dirty = cfg_we_i && (cfg_idx_i == CFG_KEY0 || cfg_idx_i == CFG_KEY1 ||
                 cfg_idx_i == CFG_KEY2 || cfg_idx_i == CFG_KEY3 || cfg_idx_i == CFG_KEYLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      klen_q <= '0; mode_q <= 1'b0; ivh_q <= '0; ivl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY0:   key_q[0] <= cfg_data_i;
        CFG_KEY1:   key_q[1] <= cfg_data_i;
        CFG_KEY2:   key_q[2] <= cfg_data_i;
        CFG_KEY3:   key_q[3] <= cfg_data_i;
        CFG_KEYLEN: klen_q <= cfg_data_i[1:0];
        CFG_MODE:   mode_q <= cfg_data_i[0];
        CFG_IVH:    ivh_q <= cfg_data_i;
        CFG_IVL:    ivl_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  aes_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .first_block_i,
    .block_high_i, .block_low_i, .cbc_i(mode_q),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  aes_back #(.MaxRoundKeys(MaxRoundKeys)) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}), .key_len_i(klen_q),
    .key_dirty_i(dirty), .iv_i({ivh_q, ivl_q}),
    .out_valid_o, .out_ready_i, .result_high_o, .result_low_o
  );
endmodule
